[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of i_clk while reset is released.
`define RDSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define RDSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/rdsm_pkg.sv]
// Shared types and constants of the dot-star regex matcher.
// No dependencies; imported by every design module of the block.
package rdsm_pkg;

    localparam int PatternTokens = 32;
    localparam int Positions     = PatternTokens + 1;
    localparam int TokensPerReg  = 8;
    localparam int TokenRegs     = PatternTokens / TokensPerReg;
    localparam int TokW          = 6;
    localparam int SymW          = 5;
    localparam int CountW        = 6;
    localparam int RegW          = TokensPerReg * TokW;
    localparam int CfgIdxW       = 3;

    localparam logic [SymW-1:0] SymAny = SymW'(26);

    localparam logic [CfgIdxW-1:0] CfgTokenCount = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgTokens0    = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgTokens1    = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgTokens2    = CfgIdxW'(3);
    localparam logic [CfgIdxW-1:0] CfgTokens3    = CfgIdxW'(4);

    typedef struct packed {
        logic            star;
        logic [SymW-1:0] sym;
    } t_token;

    // Signals one cell hands forward to the next position.
    typedef struct packed {
        logic close_carry;  // closure of the current vector
        logic adv;          // token consumed, advance to next position
        logic view_carry;   // closure of the advanced vector
    } t_link;

endpackage

[hw/rtl/rdsm_cfg_regs.sv]
// Pattern configuration registers of the dot-star regex matcher.
// Depends on rdsm_pkg; feeds per-position tokens and enables to the cells.
module rdsm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rdsm_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [rdsm_pkg::RegW-1:0]       i_cfg_data,
    output rdsm_pkg::t_token                o_tokens [rdsm_pkg::Positions],
    output logic [rdsm_pkg::Positions-1:0]  o_en
);
    import rdsm_pkg::*;

    logic [CountW-1:0] r_count;
    logic [RegW-1:0]   r_tokens [TokenRegs];
    logic [CountW-1:0] limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int r = 0; r < TokenRegs; r++) begin
                r_tokens[r] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgTokenCount: r_count     <= i_cfg_data[CountW-1:0];
                CfgTokens0:    r_tokens[0] <= i_cfg_data;
                CfgTokens1:    r_tokens[1] <= i_cfg_data;
                CfgTokens2:    r_tokens[2] <= i_cfg_data;
                CfgTokens3:    r_tokens[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A count above the token capacity is clipped to the capacity.
    assign limit = (r_count > CountW'(PatternTokens)) ? CountW'(PatternTokens) : r_count;

    always_comb begin
        for (int i = 0; i < Positions; i++) begin
            o_en[i] = (CountW'(i) < limit);
            if (i < PatternTokens) begin
                o_tokens[i] = t_token'(
                    r_tokens[i / TokensPerReg][(i % TokensPerReg) * TokW +: TokW]);
            end else begin
                o_tokens[i] = '0;
            end
        end
    end

endmodule

[hw/rtl/rdsm_cell.sv]
// One pattern position of the dot-star regex matcher: live bit, closure and step.
// Depends on rdsm_pkg; chained by the top level, one cell per position.
module rdsm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdsm_pkg::t_token            i_token,
    input  logic                        i_en,
    input  logic                        i_en_prev,
    input  logic                        i_first,
    input  logic [rdsm_pkg::SymW-1:0]   i_char,
    input  logic                        i_no_char,
    input  logic                        i_last,
    input  logic                        i_accept,
    input  rdsm_pkg::t_link             i_link,
    output rdsm_pkg::t_link             o_link,
    output logic                        o_view,
    output logic                        o_end_hit
);
    import rdsm_pkg::*;

    logic r_live;
    logic closed;
    logic hit;
    logic nxt;
    logic nview;

    // Positions beyond the token count are masked off on read.
    assign closed = (r_live & i_en_prev) | i_link.close_carry;
    assign o_link.close_carry = closed & i_token.star & i_en;

    assign hit = closed & i_en & ((i_token.sym == SymAny) || (i_token.sym == i_char));
    assign o_link.adv = hit & ~i_token.star;
    assign nxt = (hit & i_token.star) | i_link.adv;

    assign nview = nxt | i_link.view_carry;
    assign o_link.view_carry = nview & i_token.star & i_en;

    assign o_view = i_no_char ? closed : nview;
    assign o_end_hit = o_view & ~i_en & i_en_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= i_first;
        end else if (i_accept) begin
            if (i_last) begin
                r_live <= i_first;
            end else if (!i_no_char) begin
                r_live <= nxt;
            end
        end
    end

endmodule

[hw/rtl/regex_dot_star_matcher_top.sv]
// Top level of the dot-star regex matcher: handshake, output register, cell row.
// Depends on rdsm_pkg, rdsm_cfg_regs and rdsm_cell.
//
// Usage: load the pattern through the write port (index 0 is the token
// count, indexes 1 to 4 hold eight six-bit tokens each) while no transfer
// is in flight. Then stream the subject string, one letter per transfer on
// the input channel; the transfer that carries i_last_char closes the
// string. A transfer with i_no_char set leaves the live positions alone
// and reports the answer for the string seen so far.
// Each input transfer yields exactly one result transfer, held in an output
// register. The block takes one letter every cycle unless stalled; the
// cycle is set by the ripple through the row of 33 position cells, which
// computes the closure of the current positions, the step over the letter
// and the closure of the advanced positions in the same cycle.
// Reset empties the output register, clears the pattern to the empty
// pattern and leaves only the start position live.
// When the receiver stalls, the result stays in the output register and
// o_in_stall rises until it is taken; a new letter is taken in the same
// cycle that the waiting result leaves.
module regex_dot_star_matcher_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rdsm_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [rdsm_pkg::RegW-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rdsm_pkg::SymW-1:0]       i_subject_char,
    input  logic                            i_no_char,
    input  logic                            i_last_char,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_matched,
    output logic                            o_any_alive,
    output logic                            o_string_done
);
    import rdsm_pkg::*;

    t_token                 tokens [Positions];
    logic [Positions-1:0]   en;
    logic [Positions-1:0]   view;
    logic [Positions-1:0]   end_hit;
    t_link                  links [Positions+1];
    logic                   accept;

    logic r_out_valid;
    logic r_matched;
    logic r_any_alive;
    logic r_string_done;

    // The input waits only while a result is held and the receiver stalls.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    rdsm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tokens    (tokens),
        .o_en        (en)
    );

    // Position zero has no predecessor, so nothing flows into it.
    assign links[0] = '0;

    for (genvar g = 0; g < Positions; g++) begin : g_cell
        rdsm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_token   (tokens[g]),
            .i_en      (en[g]),
            .i_en_prev ((g == 0) ? 1'b1 : en[(g == 0) ? 0 : g - 1]),
            .i_first   (g == 0),
            .i_char    (i_subject_char),
            .i_no_char (i_no_char),
            .i_last    (i_last_char),
            .i_accept  (accept),
            .i_link    (links[g]),
            .o_link    (links[g+1]),
            .o_view    (view[g]),
            .o_end_hit (end_hit[g])
        );
    end

    // The last cell has no token, so its outgoing link is always idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers load with each accepted letter and need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_matched     <= (|end_hit) | (links[Positions] != '0);
            r_any_alive   <= |view;
            r_string_done <= i_last_char;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_matched     = r_matched;
    assign o_any_alive   = r_any_alive;
    assign o_string_done = r_string_done;

endmodule

[hw/rtl/rdsm_checker.sv]
// Port-level assertions for the dot-star regex matcher, bound to its top level.
// Depends on assert_macros.svh and regex_dot_star_matcher_top.
`include "assert_macros.svh"

module rdsm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic i_last_char,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_matched,
    input logic o_any_alive,
    input logic o_string_done
);

    `RDSM_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid, "result after reset")

    `RDSM_ASSERT(a_accept_gives_result, (i_in_valid && !o_in_stall) |=> o_out_valid,
        "accepted letter gave no result")

    `RDSM_ASSERT(a_stall_only_when_full, o_in_stall |-> (o_out_valid && i_out_stall),
        "input stalled with room for a result")

    `RDSM_ASSERT(a_match_is_alive, (o_out_valid && o_matched) |-> o_any_alive,
        "match reported with no live position")

    `RDSM_ASSERT(a_done_echo, (i_in_valid && !o_in_stall) |=>
        (o_string_done == $past(i_last_char)), "end of string not echoed")

endmodule

bind regex_dot_star_matcher_top rdsm_checker u_rdsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_last_char   (i_last_char),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_matched     (o_matched),
    .o_any_alive   (o_any_alive),
    .o_string_done (o_string_done)
);

[tb/match_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// Answer scoreboard for the dot-star regex matcher testbench: mirrors the
// pattern registers and the live position vector, and queues the answers due.
// Depends on rdsm_pkg.
package match_scoreboard_pkg;
    import rdsm_pkg::*;

    typedef struct packed {
        logic matched;
        logic any_alive;
        logic string_done;
    } t_match_answer;

    class match_scoreboard;
        logic [CountW-1:0]    tok_count;
        logic [RegW-1:0]      tok_reg [TokenRegs];
        logic [Positions-1:0] live;
        t_match_answer        answers_due [$];
        int                   failures;

        function new();
            tok_count = '0;
            foreach (tok_reg[r]) tok_reg[r] = '0;
            live = Positions'(1);
            failures = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] data);
            case (idx)
                CfgTokenCount: tok_count = data[CountW-1:0];
                CfgTokens0:    tok_reg[0] = data;
                CfgTokens1:    tok_reg[1] = data;
                CfgTokens2:    tok_reg[2] = data;
                CfgTokens3:    tok_reg[3] = data;
                default: ;
            endcase
        endfunction

        // A count above the row size is clamped to the row size.
        function int unsigned used_tokens();
            return (tok_count > PatternTokens) ? PatternTokens : int'(tok_count);
        endfunction

        function t_token token_at(int unsigned k);
            return t_token'(tok_reg[k / TokensPerReg][TokW * (k % TokensPerReg) +: TokW]);
        endfunction

        // A live starred token may be skipped, so it also makes the next position live.
        function logic [Positions-1:0] closure(logic [Positions-1:0] v, int unsigned n);
            t_token tok;
            for (int unsigned i = 0; i < n; i++) begin
                tok = token_at(i);
                if (v[i] && tok.star) v[i + 1] = 1'b1;
            end
            return v;
        endfunction

        function void record_letter(logic [SymW-1:0] ch, logic no_char, logic last);
            int unsigned          n;
            logic [Positions:0]   wide;
            logic [Positions-1:0] mask;
            logic [Positions-1:0] cur;
            logic [Positions-1:0] nxt;
            logic [Positions-1:0] view;
            t_token               tok;
            t_match_answer        ans;
            n = used_tokens();
            wide = ((Positions + 1)'(1) << (n + 1)) - 1;
            mask = wide[Positions-1:0];
            cur = closure(live & mask, n);
            if (!no_char) begin
                nxt = '0;
                for (int unsigned i = 0; i < n; i++) begin
                    tok = token_at(i);
                    if (cur[i] && (tok.sym == SymAny || tok.sym == ch)) begin
                        if (tok.star) nxt[i] = 1'b1;
                        else nxt[i + 1] = 1'b1;
                    end
                end
                live = nxt & mask;
                view = closure(live, n);
            end else begin
                view = cur;
            end
            ans.matched     = view[n];
            ans.any_alive   = |view;
            ans.string_done = last;
            answers_due.insert(answers_due.size(), ans);
            if (last) live = Positions'(1);
        endfunction

        function void check_answer(logic matched, logic any_alive, logic string_done);
            t_match_answer want;
            if (answers_due.size() == 0) begin
                $error("result transfer with no answer due: matched=%0b any_alive=%0b",
                       matched, any_alive);
                failures++;
                return;
            end
            want = answers_due.pop_front();
            if (matched !== want.matched) begin
                $error("matched: expected %0b, actual %0b", want.matched, matched);
                failures++;
            end
            if (any_alive !== want.any_alive) begin
                $error("any_alive: expected %0b, actual %0b", want.any_alive, any_alive);
                failures++;
            end
            if (string_done !== want.string_done) begin
                $error("string_done: expected %0b, actual %0b", want.string_done, string_done);
                failures++;
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the dot-star regex matcher testbench: clock, reset, drivers, monitor.
// Depends on rdsm_pkg, match_scoreboard_pkg and regex_dot_star_matcher_top.
module tb_top;
    import rdsm_pkg::*;
    import match_scoreboard_pkg::*;

    typedef logic [SymW-1:0] t_text [$];

    // Longest receiver hold-off, and the watchdog limit on cycles without a transfer or a write.
    localparam int HoldCycles = 300;
    localparam int WatchLimit = 2000;
    localparam int PhaseItems = 400;

    localparam logic [CfgIdxW-1:0] TokRegIndex [TokenRegs] =
        '{CfgTokens0, CfgTokens1, CfgTokens2, CfgTokens3};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [RegW-1:0]    i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [SymW-1:0]    i_subject_char;
    logic               i_no_char;
    logic               i_last_char;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_matched;
    logic               o_any_alive;
    logic               o_string_done;

    match_scoreboard sb;

    // Transfer flags, set at the rising edge and read by the drivers at the falling edge.
    bit in_xfer;
    bit out_xfer;
    int idle_count;
    int items_sent;

    // Idling controls and the long receiver hold-off request.
    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_req;
    bit hold_done;
    int hold_left;

    // The pattern as last loaded, kept so that matching strings can be built from it.
    t_token pat_tok [PatternTokens];
    int     pat_count;
    int     phase_end;
    int     run_end;

    regex_dot_star_matcher_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_subject_char (i_subject_char),
        .i_no_char      (i_no_char),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_matched      (o_matched),
        .o_any_alive    (o_any_alive),
        .o_string_done  (o_string_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor. Everything is sampled at the rising edge, before the block's registers
    // move, so the order of processes inside the time step does not matter. A register
    // write, a result transfer and an input transfer are fed to the scoreboard in that
    // order; a write never coincides with a transfer, and the result taken at an edge
    // always belongs to an item accepted at an earlier edge.
    always @(posedge i_clk) begin
        in_xfer  = i_rst_n && i_in_valid && !o_in_stall;
        out_xfer = i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && i_cfg_we) sb.write_reg(i_cfg_index, i_cfg_data);
        if (out_xfer) sb.check_answer(o_matched, o_any_alive, o_string_done);
        if (in_xfer) sb.record_letter(i_subject_char, i_no_char, i_last_char);
        // Watchdog: the run is stuck when nothing has moved for too long.
        if (in_xfer || out_xfer || i_cfg_we) begin
            idle_count = 0;
        end else begin
            idle_count++;
        end
        if (idle_count >= WatchLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver. It stalls at random at the rate of the current phase. A hold-off
    // request makes it stall for a long stretch, counted here, while the sender keeps
    // offering items, so the output register fills and the block stalls its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HoldCycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Mostly letters from a small alphabet so that patterns match now and then;
    // sometimes any 5-bit code, the out-of-range ones included.
    function automatic logic [SymW-1:0] random_letter();
        if ($urandom_range(9) == 0) return SymW'($urandom_range(31));
        return SymW'($urandom_range(2));
    endfunction

    // Offers one item and returns at the falling edge after its transfer, with valid
    // still high. Idle cycles before the item follow the sender's idling rate.
    task automatic send_item(input logic [SymW-1:0] ch, input logic no_char,
                             input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_subject_char <= ch;
        i_no_char      <= no_char;
        i_last_char    <= last;
        @(negedge i_clk);
        while (!in_xfer) @(negedge i_clk);
        items_sent++;
    endtask

    // Stops the sender and waits until every answer due has been taken, then lets
    // the output register settle.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Writes all five registers while the block is idle. The count write carries
    // random upper bits, which the block has to ignore.
    task automatic load_pattern(input logic [CountW-1:0] count);
        logic [RegW-1:0] regs_data [TokenRegs];
        logic [RegW-1:0] count_data;
        settle();
        pat_count = count;
        for (int r = 0; r < TokenRegs; r++) begin
            for (int j = 0; j < TokensPerReg; j++) begin
                regs_data[r][TokW * j +: TokW] = pat_tok[r * TokensPerReg + j];
            end
        end
        count_data = RegW'({$urandom(), $urandom()});
        count_data[CountW-1:0] = count;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CfgTokenCount;
        i_cfg_data  <= count_data;
        @(negedge i_clk);
        for (int r = 0; r < TokenRegs; r++) begin
            i_cfg_index <= TokRegIndex[r];
            i_cfg_data  <= regs_data[r];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic fill_tokens(input t_token tok);
        foreach (pat_tok[i]) pat_tok[i] = tok;
    endtask

    task automatic set_tok(input int idx, input logic [SymW-1:0] sym, input logic star);
        pat_tok[idx].sym  = sym;
        pat_tok[idx].star = star;
    endtask

    // Sends one string. An empty string is a single no-letter item that closes it.
    // Now and then a no-letter item falls inside the string, or closes it after the
    // last letter.
    task automatic send_text(input t_text text);
        bit closer;
        closer = ($urandom_range(19) == 0);
        if (text.size() == 0) begin
            send_item(random_letter(), 1'b1, 1'b1);
        end else begin
            foreach (text[i]) begin
                if ($urandom_range(19) == 0) send_item(random_letter(), 1'b1, 1'b0);
                send_item(text[i], 1'b0, (i == text.size() - 1) && !closer);
            end
            if (closer) send_item(random_letter(), 1'b1, 1'b1);
        end
    endtask

    // Builds a string from the loaded pattern, so most strings get deep into it,
    // then breaks some of them by changing, dropping or adding one letter.
    task automatic send_matching_text();
        t_text           text;
        t_token          tok;
        int unsigned     n;
        int unsigned     reps;
        logic [SymW-1:0] letter;
        n = (pat_count > PatternTokens) ? PatternTokens : pat_count;
        for (int unsigned i = 0; i < n; i++) begin
            tok = pat_tok[i];
            reps = tok.star ? $urandom_range(3) : 1;
            repeat (reps) begin
                letter = (tok.sym == SymAny) ? random_letter() : tok.sym;
                text.insert(text.size(), letter);
            end
        end
        if ($urandom_range(99) < 35) begin
            case ($urandom_range(2))
                0: if (text.size() > 0) text[$urandom_range(text.size() - 1)] = random_letter();
                1: if (text.size() > 0) text.delete($urandom_range(text.size() - 1));
                default: text.insert($urandom_range(text.size()), random_letter());
            endcase
        end
        while (text.size() > 40) void'(text.pop_back());
        send_text(text);
    endtask

    task automatic send_noise();
        t_text text;
        repeat ($urandom_range(8)) text.insert(text.size(), SymW'($urandom_range(31)));
        send_text(text);
    endtask

    // Random pattern: mostly short, some long, a few with any count the field holds.
    // Tokens use a small alphabet and the any symbol; some are fully random codes.
    task automatic pick_pattern();
        logic [CountW-1:0] count;
        int                roll;
        roll = $urandom_range(9);
        if (roll < 7) count = CountW'($urandom_range(6));
        else if (roll < 9) count = CountW'($urandom_range(PatternTokens, 7));
        else count = CountW'($urandom_range(63));
        foreach (pat_tok[i]) begin
            if ($urandom_range(19) < 3) begin
                pat_tok[i] = t_token'(TokW'($urandom_range(63)));
            end else begin
                pat_tok[i].sym  = ($urandom_range(3) == 0) ? SymAny : SymW'($urandom_range(2));
                pat_tok[i].star = ($urandom_range(99) < 35);
            end
        end
        load_pattern(count);
    endtask

    initial begin
        sb = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CfgTokenCount;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_subject_char = '0;
        i_no_char      = 1'b0;
        i_last_char    = 1'b0;
        i_out_stall    = 1'b0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The empty pattern left by reset matches only the empty string. A no-letter
        // item that does not close the string keeps the start position live.
        send_item(5'd0, 1'b1, 1'b1);
        send_item(5'd25, 1'b0, 1'b1);
        send_item(5'd7, 1'b1, 1'b0);
        send_item(5'd7, 1'b1, 1'b1);

        // "c*a.b": a skipped star, a literal, the any symbol; then a partial match and
        // the empty string, which leaves positions alive but does not match.
        fill_tokens('0);
        set_tok(0, 5'd2, 1'b1);
        set_tok(1, 5'd0, 1'b0);
        set_tok(2, SymAny, 1'b0);
        set_tok(3, 5'd1, 1'b0);
        load_pattern(CountW'(4));
        send_item(5'd2, 1'b0, 1'b0);
        send_item(5'd2, 1'b0, 1'b0);
        send_item(5'd0, 1'b0, 1'b0);
        send_item(5'd25, 1'b0, 1'b0);
        send_item(5'd1, 1'b0, 1'b1);
        send_item(5'd0, 1'b0, 1'b0);
        send_item(5'd1, 1'b0, 1'b1);
        send_item(5'd0, 1'b1, 1'b1);

        // Star on any takes any run of letters, an out-of-range code as well.
        fill_tokens('0);
        set_tok(0, SymAny, 1'b1);
        load_pattern(CountW'(1));
        send_item(5'd25, 1'b0, 1'b0);
        send_item(5'd31, 1'b0, 1'b1);

        // Unused symbol codes are literals that only an equal code matches.
        fill_tokens('0);
        set_tok(0, 5'd31, 1'b0);
        set_tok(1, 5'd27, 1'b1);
        load_pattern(CountW'(2));
        send_item(5'd31, 1'b0, 1'b1);
        send_item(5'd0, 1'b0, 1'b1);

        // Thirty-two starred z's under the largest count, which is clamped: the empty
        // string matches through closure over the whole row.
        fill_tokens(t_token'({1'b1, 5'd25}));
        load_pattern(CountW'(63));
        send_item(5'd0, 1'b1, 1'b1);
        send_item(5'd25, 1'b0, 1'b0);
        send_item(5'd25, 1'b0, 1'b1);

        // All-ones token registers, first with the full row, then with no tokens.
        fill_tokens('1);
        load_pattern(CountW'(PatternTokens));
        send_item(5'd0, 1'b0, 1'b1);
        load_pattern(CountW'(0));
        send_item(5'd3, 1'b1, 1'b1);

        // Random part in four idling phases: none, sender idle, receiver stalling,
        // both. Each pattern gets a run of strings, and the drain before each reload
        // is where the sender waits for every answer due.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end) begin
                pick_pattern();
                if (phase == 0 && !hold_done) begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                run_end = items_sent + $urandom_range(60, 20);
                while (items_sent < run_end) begin
                    if ($urandom_range(99) < 15) send_noise();
                    else send_matching_text();
                end
            end
        end

        settle();
        repeat (5) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
